>>> design/preregulator_pi_tracking_control_unit_assert.svh
// ----------------------------------------------------------------------------
// Pre-regulator tracking control: assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef PREREGULATOR_PI_TRACKING_CONTROL_UNIT_ASSERT_SVH
`define PREREGULATOR_PI_TRACKING_CONTROL_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PPTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pptc assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PPTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pptc assertion failed");

`endif

>>> design/pptc_pkg.sv
// ----------------------------------------------------------------------------
// Pre-regulator tracking control package
// Widths, limits, register indexes, payload types and shared helpers.
// ----------------------------------------------------------------------------
package pptc_pkg;

    localparam int unsigned VOUT_MAX     = 20000;
    localparam int unsigned PWM_STEPS    = 1024;
    localparam int unsigned OV_LIMIT     = VOUT_MAX + 2000;
    localparam int unsigned TRACK_MARGIN = 500;
    localparam int unsigned INTEG_MAX    = 200000;

    localparam int unsigned MEAS_W   = 16;
    localparam int unsigned VOUT_W   = 15;
    localparam int unsigned DUTY_W   = 10;
    localparam int unsigned RES_W    = 10;
    localparam int unsigned HEAD_W   = 14;
    localparam int unsigned PROD_W   = MEAS_W + RES_W;
    localparam int unsigned QUOT_W   = 17;
    localparam int unsigned ERR_W    = 18;
    localparam int unsigned INTEG_W  = 19;
    localparam int unsigned IQ_W     = 13;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] PWM_FULL = DUTY_W'(PWM_STEPS - 1);

    // x / 1000 == (x * DIV_MULT) >> DIV_SHIFT, exact for any PROD_W-bit x
    localparam int unsigned   DIV_SHIFT = 36;
    localparam logic [26:0]   DIV_MULT  = 27'd68719477;

    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_SET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_OPEN_V    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_RES       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FLOOR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SLOPE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_CEILING   = 3'd7;

    localparam logic [MEAS_W-1:0] RST_CURRENT_LIMIT = 16'd3000;
    localparam logic [HEAD_W-1:0] RST_HEAD_FLOOR    = 14'd2000;
    localparam logic [RES_W-1:0]  RST_HEAD_SLOPE    = 10'd500;
    localparam logic [HEAD_W-1:0] RST_HEAD_CEILING  = 14'd4000;

    typedef enum logic [1:0] {
        FAULT_NONE       = 2'd0,
        FAULT_OVERVOLT   = 2'd1,
        FAULT_TRACK_LOSS = 2'd2
    } t_fault;

    typedef struct packed {
        logic              out_enable;
        logic [MEAS_W-1:0] out_voltage;
        logic [MEAS_W-1:0] out_current;
        logic [MEAS_W-1:0] pre_voltage;
        logic [MEAS_W-1:0] bus_voltage;
    } t_ctl_in;

    typedef struct packed {
        logic [VOUT_W-1:0] reference_target;
        logic [DUTY_W-1:0] buck_duty;
        logic [DUTY_W-1:0] boost_duty;
        logic              current_limited;
        t_fault            fault_code;
        logic              shutdown;
    } t_ctl_out;

    function automatic logic [QUOT_W-1:0] div1000(input logic [PROD_W-1:0] x);
        logic [PROD_W+27-1:0] prod;
        prod = x * DIV_MULT;
        return QUOT_W'(prod >> DIV_SHIFT);
    endfunction

endpackage

>>> design/pptc_in_if.sv
// ----------------------------------------------------------------------------
// Pre-regulator tracking control: measurement request channel
// Valid/ready channel carrying one set of measurements per control tick.
// ----------------------------------------------------------------------------
interface pptc_in_if;
    logic              valid;
    logic              ready;
    pptc_pkg::t_ctl_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/pptc_out_if.sv
// ----------------------------------------------------------------------------
// Pre-regulator tracking control: result channel
// Valid/ready channel carrying target, leg duties and fault status.
// ----------------------------------------------------------------------------
interface pptc_out_if;
    logic               valid;
    logic               ready;
    pptc_pkg::t_ctl_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/preregulator_pi_tracking_control_unit.sv
// ----------------------------------------------------------------------------
// Pre-regulator tracking control unit
// PI control of a buck/boost pre-regulator that tracks the output target.
// ----------------------------------------------------------------------------
// One request per control tick. A request with the output enable low clears
// the PI integrator and yields no result; otherwise one result follows. The
// block is a six-register pipeline: input, products, divide-by-1000 by
// reciprocal multiply, target and error, integrator update, result. One
// request can be accepted every cycle while the result is taken or the
// pipeline has room. Each stage advances on its own, so a held result
// stalls only the stages behind it once they fill. Write configuration only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module preregulator_pi_tracking_control_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pptc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pptc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pptc_in_if.sink                          i_in,
    pptc_out_if.source                       o_out
);

    localparam int unsigned MW = pptc_pkg::MEAS_W;
    localparam int unsigned VW = pptc_pkg::VOUT_W;
    localparam int unsigned HW = pptc_pkg::HEAD_W;
    localparam int unsigned RW = pptc_pkg::RES_W;
    localparam int unsigned PW = pptc_pkg::PROD_W;
    localparam int unsigned QW = pptc_pkg::QUOT_W;
    localparam int unsigned EW = pptc_pkg::ERR_W;
    localparam int unsigned IW = pptc_pkg::INTEG_W;
    localparam int unsigned QI = pptc_pkg::IQ_W;
    localparam int unsigned DW = pptc_pkg::DUTY_W;

    localparam logic signed [19:0] VMAX_S20  = 20'(pptc_pkg::VOUT_MAX);
    localparam logic signed [19:0] IMAX_S20  = 20'(pptc_pkg::INTEG_MAX);
    localparam logic signed [19:0] IMIN_S20  = -20'(pptc_pkg::INTEG_MAX);
    localparam logic signed [21:0] DFULL_S22 = 22'(pptc_pkg::PWM_STEPS - 1);

    // configuration registers
    logic          r_batt_mode;
    logic [VW-1:0] r_vset;
    logic [MW-1:0] r_ilim;
    logic [VW-1:0] r_batt_ocv;
    logic [RW-1:0] r_batt_res;
    logic [HW-1:0] r_head_floor;
    logic [RW-1:0] r_head_slope;
    logic [HW-1:0] r_head_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batt_mode  <= 1'b0;
            r_vset       <= '0;
            r_ilim       <= pptc_pkg::RST_CURRENT_LIMIT;
            r_batt_ocv   <= '0;
            r_batt_res   <= '0;
            r_head_floor <= pptc_pkg::RST_HEAD_FLOOR;
            r_head_slope <= pptc_pkg::RST_HEAD_SLOPE;
            r_head_ceil  <= pptc_pkg::RST_HEAD_CEILING;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pptc_pkg::CFG_BATTERY_MODE:  r_batt_mode  <= i_cfg_data[0];
                pptc_pkg::CFG_VOLTAGE_SET:   r_vset       <= i_cfg_data[VW-1:0];
                pptc_pkg::CFG_CURRENT_LIMIT: r_ilim       <= i_cfg_data[MW-1:0];
                pptc_pkg::CFG_BATT_OPEN_V:   r_batt_ocv   <= i_cfg_data[VW-1:0];
                pptc_pkg::CFG_BATT_RES:      r_batt_res   <= i_cfg_data[RW-1:0];
                pptc_pkg::CFG_HEAD_FLOOR:    r_head_floor <= i_cfg_data[HW-1:0];
                pptc_pkg::CFG_HEAD_SLOPE:    r_head_slope <= i_cfg_data[RW-1:0];
                pptc_pkg::CFG_HEAD_CEILING:  r_head_ceil  <= i_cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and per-stage advance
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r_o_v;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

    assign rdy_o = !r_o_v || o_out.ready;
    assign rdy5  = !r5_v  || rdy_o;
    assign rdy4  = !r4_v  || rdy5;
    assign rdy3  = !r3_v  || rdy4;
    assign rdy2  = !r2_v  || rdy3;
    assign rdy1  = !r1_v  || rdy2;

    assign i_in.ready = rdy1;

    // stage 1: input register
    pptc_pkg::t_ctl_in r1_d;

    // stage 2: products
    logic          r2_on;
    logic [MW-1:0] r2_vout, r2_iout, r2_vpre, r2_vbus;
    logic [PW-1:0] r2_psag, r2_phead;

    // stage 3: quotients
    logic          r3_on;
    logic [MW-1:0] r3_vout, r3_iout, r3_vpre, r3_vbus;
    logic [QW-1:0] r3_sag, r3_hq;

    // stage 4: target, error, faults
    logic                   r4_on;
    logic [VW-1:0]          r4_target;
    logic                   r4_limited;
    pptc_pkg::t_fault       r4_fault;
    logic signed [EW-1:0]   r4_err;
    logic                   r4_buck;

    // stage 5: integrator applied
    logic [VW-1:0]          r5_target;
    logic                   r5_limited;
    pptc_pkg::t_fault       r5_fault;
    logic signed [EW-1:0]   r5_err;
    logic signed [QI-1:0]   r5_iq;
    logic                   r5_buck;

    logic signed [IW-1:0]   r_integ;
    pptc_pkg::t_ctl_out     r_o_d;

    // stage 4 combinational
    logic signed [18:0] batt_raw;
    logic [VW-1:0]      batt_t;
    logic [VW-1:0]      base_t;
    logic               limited;
    logic [MW-1:0]      over;
    logic signed [19:0] lim_raw;
    logic [VW-1:0]      n_target;
    logic [17:0]        head_raw;
    logic [HW-1:0]      head;
    logic [MW-1:0]      want_raw;
    logic [MW-1:0]      want_cap;
    logic [MW-1:0]      want;
    logic signed [EW-1:0] n_err;
    pptc_pkg::t_fault   n_fault;

    always_comb begin
        batt_raw = $signed({4'b0, r_batt_ocv}) - $signed({2'b0, r3_sag});
        if (batt_raw < 0) begin
            batt_t = '0;
        end else if (batt_raw > 19'(pptc_pkg::VOUT_MAX)) begin
            batt_t = VW'(pptc_pkg::VOUT_MAX);
        end else begin
            batt_t = batt_raw[VW-1:0];
        end
        base_t  = r_batt_mode ? batt_t : r_vset;

        limited = (r3_iout >= r_ilim);
        over    = r3_iout - r_ilim;
        lim_raw = $signed({5'b0, base_t}) - $signed({2'b0, over, 2'b0});
        if (!limited) begin
            n_target = base_t;
        end else if (lim_raw < 0) begin
            n_target = '0;
        end else if (lim_raw > VMAX_S20) begin
            n_target = VW'(pptc_pkg::VOUT_MAX);
        end else begin
            n_target = lim_raw[VW-1:0];
        end

        // floor above ceiling falls out as ceiling here
        head_raw = {4'b0, r_head_floor} + {1'b0, r3_hq};
        head     = (head_raw > {4'b0, r_head_ceil}) ? r_head_ceil : head_raw[HW-1:0];

        want_raw = {1'b0, n_target} + {2'b0, head};
        want_cap = MW'(pptc_pkg::VOUT_MAX) + {2'b0, r_head_ceil};
        want     = (want_raw > want_cap) ? want_cap : want_raw;
        n_err    = $signed({2'b0, want}) - $signed({2'b0, r3_vpre});

        // tracking loss takes priority over overvoltage
        if ({1'b0, r3_vpre} + 17'(pptc_pkg::TRACK_MARGIN) < {1'b0, r3_vout}) begin
            n_fault = pptc_pkg::FAULT_TRACK_LOSS;
        end else if (r3_vout > MW'(pptc_pkg::OV_LIMIT)) begin
            n_fault = pptc_pkg::FAULT_OVERVOLT;
        end else begin
            n_fault = pptc_pkg::FAULT_NONE;
        end
    end

    // stage 5 combinational: integrate, clamp, divide by 64 toward zero
    logic signed [19:0]   integ_sum;
    logic signed [IW-1:0] n_integ;
    logic signed [IW-1:0] integ_adj;
    logic signed [QI-1:0] n_iq;

    always_comb begin
        integ_sum = 20'(r_integ) + 20'(r4_err);
        if (integ_sum > IMAX_S20) begin
            n_integ = IW'(IMAX_S20);
        end else if (integ_sum < IMIN_S20) begin
            n_integ = IW'(IMIN_S20);
        end else begin
            n_integ = integ_sum[IW-1:0];
        end
        integ_adj = n_integ[IW-1] ? n_integ + IW'(63) : n_integ;
        n_iq      = QI'(integ_adj >>> 6);
    end

    // output stage combinational: P term plus I term, clamp, leg select
    logic signed [21:0] e6;
    logic signed [21:0] duty_raw;
    logic [DW-1:0]      duty;
    pptc_pkg::t_ctl_out n_o_d;

    always_comb begin
        e6       = (22'(r5_err) <<< 2) + (22'(r5_err) <<< 1);
        duty_raw = e6 + 22'(r5_iq);
        if (duty_raw < 0) begin
            duty = '0;
        end else if (duty_raw > DFULL_S22) begin
            duty = pptc_pkg::PWM_FULL;
        end else begin
            duty = duty_raw[DW-1:0];
        end
        n_o_d.reference_target = r5_target;
        n_o_d.buck_duty        = r5_buck ? duty : pptc_pkg::PWM_FULL;
        n_o_d.boost_duty       = r5_buck ? pptc_pkg::PWM_FULL : duty;
        n_o_d.current_limited  = r5_limited;
        n_o_d.fault_code       = r5_fault;
        n_o_d.shutdown         = (r5_fault != pptc_pkg::FAULT_NONE);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r_o_v   <= 1'b0;
            r_integ <= '0;
        end else begin
            if (rdy1) r1_v <= i_in.valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
            // drop output-off requests here, as they clear the integrator
            if (rdy5) r5_v <= r4_v && r4_on;
            if (rdy_o) r_o_v <= r5_v;
            if (rdy5 && r4_v) begin
                r_integ <= r4_on ? n_integ : '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_d <= i_in.data;
        end
        if (rdy2) begin
            r2_on    <= r1_d.out_enable;
            r2_vout  <= r1_d.out_voltage;
            r2_iout  <= r1_d.out_current;
            r2_vpre  <= r1_d.pre_voltage;
            r2_vbus  <= r1_d.bus_voltage;
            r2_psag  <= r1_d.out_current * r_batt_res;
            r2_phead <= r1_d.out_current * r_head_slope;
        end
        if (rdy3) begin
            r3_on   <= r2_on;
            r3_vout <= r2_vout;
            r3_iout <= r2_iout;
            r3_vpre <= r2_vpre;
            r3_vbus <= r2_vbus;
            r3_sag  <= pptc_pkg::div1000(r2_psag);
            r3_hq   <= pptc_pkg::div1000(r2_phead);
        end
        if (rdy4) begin
            r4_on      <= r3_on;
            r4_target  <= n_target;
            r4_limited <= limited;
            r4_fault   <= n_fault;
            r4_err     <= n_err;
            r4_buck    <= (want < r3_vbus);
        end
        if (rdy5) begin
            r5_target  <= r4_target;
            r5_limited <= r4_limited;
            r5_fault   <= r4_fault;
            r5_err     <= r4_err;
            r5_iq      <= n_iq;
            r5_buck    <= r4_buck;
        end
        if (rdy_o) begin
            r_o_d <= n_o_d;
        end
    end

    assign o_out.valid = r_o_v;
    assign o_out.data  = r_o_d;

endmodule

>>> design/pptc_checker.sv
// ----------------------------------------------------------------------------
// Pre-regulator tracking control: port checker
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
`include "preregulator_pi_tracking_control_unit_assert.svh"

module pptc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input pptc_pkg::t_ctl_out i_out_data
);

    `PPTC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    `PPTC_ASSERT_NOW(a_shutdown_fault, i_out_valid, i_out_data.shutdown == (i_out_data.fault_code != pptc_pkg::FAULT_NONE))

    `PPTC_ASSERT_NOW(a_leg_parked, i_out_valid, (i_out_data.buck_duty == pptc_pkg::PWM_FULL) || (i_out_data.boost_duty == pptc_pkg::PWM_FULL))

    `PPTC_ASSERT_NOW(a_ready_when_empty, !i_out_valid, i_in_ready)

endmodule

bind preregulator_pi_tracking_control_unit pptc_checker u_pptc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
